>>> rtl/dfrc_pkg.sv
// ----------------------------------------------------------------------------
// dfrc_pkg
// Shared types and constants for the frame-slot ring controller: event and
// command codes, configuration register map and the beat payload structs.
// ----------------------------------------------------------------------------
package dfrc_pkg;

    // default ring capacity in slots
    localparam int MAX_SLOTS_DEF = 64;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAMES = 1'd0,
        CFG_FRAME_SIZE = 1'd1
    } t_cfg_idx;

    // register reset values
    localparam logic [6:0]  MAX_FRAMES_RST = 7'd64;
    localparam logic [16:0] FRAME_SIZE_RST = 17'd256;

    // event codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_REC_SETUP  = 3'd0,
        MODE_PLAY_SETUP = 3'd1,
        MODE_HOST_WRITE = 3'd2,
        MODE_HOST_READ  = 3'd3,
        MODE_DMA_DONE   = 3'd4
    } t_mode;

    // status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_WR_FULL = 2'd1,
        STATUS_RD_WAIT = 2'd2
    } t_status;

    // commands to the converter
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START_OUT = 3'd1,
        CMD_START_IN  = 3'd2,
        CMD_RESTART   = 3'd3,
        CMD_PAUSE     = 3'd4
    } t_cmd;

    // slot wrap unit states
    typedef enum logic [1:0] {
        WRAP_IDLE = 2'd0,
        WRAP_RUN  = 2'd1,
        WRAP_DONE = 2'd2
    } t_wrap_state;

    // configuration register contents
    typedef struct packed {
        logic [6:0]  max_frames;
        logic [16:0] frame_size;
    } t_cfg;

    // input beat
    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] frames;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  dsp_command;
        logic [15:0] block_length_minus_one;
        logic [5:0]  first_slot;
        logic [6:0]  fill_count;
        logic        dma_is_paused;
    } t_out_item;

endpackage

>>> rtl/dfrc_event_core.sv
// ----------------------------------------------------------------------------
// dfrc_event_core
// Ring state (fill count, host slot, run/pause/playback flags) and the
// single-pass event logic that produces one result per event, with a small
// multi-cycle wrap unit for host slot advances reaching twice the ring size.
// ----------------------------------------------------------------------------
module dfrc_event_core #(
    parameter int MAX_SLOTS = dfrc_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_step,
    input  dfrc_pkg::t_in_item  i_item,
    input  dfrc_pkg::t_cfg      i_cfg,
    output logic                o_ready,
    output dfrc_pkg::t_out_item o_result
);

    // usable capacity is bounded by the 7-bit max_frames register
    localparam int         CAP    = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
    localparam int         FILL_W = $clog2(CAP + 1);
    localparam int         SLOT_W = $clog2(CAP);
    localparam logic [7:0] CAP_8  = 8'(CAP);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_running, n_running;
    logic              r_paused, n_paused;
    logic              r_playback, n_playback;

    dfrc_pkg::t_wrap_state r_wrap, n_wrap;
    logic [7:0]        r_rem, n_rem;
    logic [2:0]        r_k, n_k;

    logic [7:0]        mf_8;
    logic [7:0]        emax_8;
    logic [7:0]        fill_8;
    logic [7:0]        frames_8;
    logic [7:0]        slot_8;
    logic [7:0]        base_8;
    logic [7:0]        wsum_8;
    logic [7:0]        psum_8;
    logic [7:0]        fast_rem_8;
    logic [15:0]       dshift_16;
    logic              xfer_ok;
    logic              need_slow;
    logic [7:0]        slot_next_8;
    logic [15:0]       blen;
    logic [15:0]       first_16;
    logic [15:0]       fill_16;
    logic [7:0]        first_8;
    logic [15:0]       blen_out;
    dfrc_pkg::t_status status;
    dfrc_pkg::t_cmd    cmd;

    // effective ring size clamped to 1..capacity
    always_comb begin
        mf_8 = {1'b0, i_cfg.max_frames};
        if (mf_8 == 8'd0) begin
            emax_8 = 8'd1;
        end else if (mf_8 > CAP_8) begin
            emax_8 = CAP_8;
        end else begin
            emax_8 = mf_8;
        end
    end

    // operands and slot advance with wrap
    assign fill_8     = 8'(r_fill);
    assign frames_8   = {1'b0, i_item.frames};
    assign slot_8     = 8'(r_slot);
    assign base_8     = (slot_8 >= emax_8) ? 8'd0 : slot_8;
    assign wsum_8     = fill_8 + frames_8;
    assign psum_8     = base_8 + frames_8;
    assign fast_rem_8 = (psum_8 >= emax_8) ? (psum_8 - emax_8) : psum_8;
    assign blen       = 16'(i_cfg.frame_size - 17'd1);

    // accepted host transfer whose slot sum reaches twice the ring size
    assign xfer_ok = ((i_item.mode == dfrc_pkg::MODE_HOST_WRITE) && !(wsum_8 > emax_8))
                  || ((i_item.mode == dfrc_pkg::MODE_HOST_READ) && !(fill_8 < frames_8));
    assign need_slow   = xfer_ok && ({1'b0, psum_8} >= {emax_8, 1'b0});
    assign slot_next_8 = need_slow ? r_rem : fast_rem_8;
    assign o_ready     = !need_slow || (r_wrap == dfrc_pkg::WRAP_DONE);

    // wrap unit next state
    always_comb begin
        n_wrap = r_wrap;
        case (r_wrap)
            dfrc_pkg::WRAP_IDLE: begin
                if (i_valid && need_slow) begin
                    n_wrap = dfrc_pkg::WRAP_RUN;
                end
            end
            dfrc_pkg::WRAP_RUN: begin
                if (r_k == 3'd0) begin
                    n_wrap = dfrc_pkg::WRAP_DONE;
                end
            end
            dfrc_pkg::WRAP_DONE: begin
                if (i_step) begin
                    n_wrap = dfrc_pkg::WRAP_IDLE;
                end
            end
            default: begin
                n_wrap = dfrc_pkg::WRAP_IDLE;
            end
        endcase
    end

    // wrap unit datapath: one shifted compare and subtract per cycle
    assign dshift_16 = {8'd0, emax_8} << r_k;

    always_comb begin
        n_rem = r_rem;
        n_k   = r_k;
        case (r_wrap)
            dfrc_pkg::WRAP_IDLE: begin
                n_rem = psum_8;
                n_k   = 3'd7;
            end
            dfrc_pkg::WRAP_RUN: begin
                if ({8'd0, r_rem} >= dshift_16) begin
                    n_rem = r_rem - dshift_16[7:0];
                end
                n_k = r_k - 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= dfrc_pkg::WRAP_IDLE;
            r_rem  <= '0;
            r_k    <= '0;
        end else begin
            r_wrap <= n_wrap;
            r_rem  <= n_rem;
            r_k    <= n_k;
        end
    end

    // event decode and next state
    always_comb begin
        n_fill     = r_fill;
        n_slot     = r_slot;
        n_running  = r_running;
        n_paused   = r_paused;
        n_playback = r_playback;
        status     = dfrc_pkg::STATUS_OK;
        cmd        = dfrc_pkg::CMD_NONE;
        blen_out   = '0;
        first_8    = '0;
        case (i_item.mode)
            dfrc_pkg::MODE_REC_SETUP: begin
                n_fill     = '0;
                n_slot     = '0;
                n_running  = 1'b1;
                n_paused   = 1'b0;
                n_playback = 1'b0;
                cmd        = dfrc_pkg::CMD_START_IN;
                blen_out   = blen;
            end
            dfrc_pkg::MODE_PLAY_SETUP: begin
                n_fill     = '0;
                n_slot     = '0;
                n_running  = 1'b0;
                n_paused   = 1'b0;
                n_playback = 1'b1;
            end
            dfrc_pkg::MODE_HOST_WRITE: begin
                if (wsum_8 > emax_8) begin
                    status = dfrc_pkg::STATUS_WR_FULL;
                end else begin
                    first_8 = base_8;
                    n_slot  = SLOT_W'(slot_next_8);
                    n_fill  = FILL_W'(wsum_8);
                    if (!r_running) begin
                        cmd       = dfrc_pkg::CMD_START_OUT;
                        blen_out  = blen;
                        n_running = 1'b1;
                    end else if (r_paused) begin
                        cmd      = dfrc_pkg::CMD_RESTART;
                        n_paused = 1'b0;
                    end
                end
            end
            dfrc_pkg::MODE_HOST_READ: begin
                if (fill_8 < frames_8) begin
                    status = dfrc_pkg::STATUS_RD_WAIT;
                end else begin
                    first_8 = base_8;
                    n_slot  = SLOT_W'(slot_next_8);
                    n_fill  = FILL_W'(fill_8 - frames_8);
                end
            end
            dfrc_pkg::MODE_DMA_DONE: begin
                if (r_playback) begin
                    if (r_fill != '0) begin
                        n_fill = r_fill - FILL_W'(1);
                        if (r_fill == FILL_W'(1)) begin
                            cmd      = dfrc_pkg::CMD_PAUSE;
                            n_paused = 1'b1;
                        end
                    end
                end else if (fill_8 < emax_8) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // result fields
    assign first_16 = 16'(first_8);
    assign fill_16  = 16'(n_fill);

    always_comb begin
        o_result.status                 = status;
        o_result.dsp_command            = cmd;
        o_result.block_length_minus_one = blen_out;
        o_result.first_slot             = first_16[5:0];
        o_result.fill_count             = fill_16[6:0];
        o_result.dma_is_paused          = n_paused;
    end

    // state update on each processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_slot     <= '0;
            r_running  <= 1'b0;
            r_paused   <= 1'b0;
            r_playback <= 1'b0;
        end else if (i_step) begin
            r_fill     <= n_fill;
            r_slot     <= n_slot;
            r_running  <= n_running;
            r_paused   <= n_paused;
            r_playback <= n_playback;
        end
    end

endmodule

>>> rtl/dma_frame_ring_controller_unit.sv
// ----------------------------------------------------------------------------
// dma_frame_ring_controller_unit
// Frame-slot ring controller: tracks ring fill, host slot and DMA state and
// issues converter commands, one result beat per event beat.
// ----------------------------------------------------------------------------
// Takes one event beat per clock when nothing stalls and returns exactly one
// result beat for it: the event is captured in an input register, evaluated
// against the ring state in a single pass, and the result is registered in an
// output register, while the state updates on the same edge. A host transfer
// whose slot advance reaches twice the ring size (only a read of more frames
// than the ring holds after max_frames shrinks) needs a full remainder; that
// event waits in the input register while the wrap unit works, and the input
// stalls meanwhile. A stalled output holds the result and backs up into the
// input register; the ring state is a single register set, so each event sees
// the state left by the one before it. Configuration writes take effect on the
// next edge; the user must make them only while no event is in flight, as the
// block itself does not enforce this.
module dma_frame_ring_controller_unit #(
    parameter int MAX_SLOTS = dfrc_pkg::MAX_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dfrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dfrc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  dfrc_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output dfrc_pkg::t_out_item                o_out
);

    dfrc_pkg::t_cfg      r_cfg, n_cfg;
    logic                r_in_valid;
    dfrc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    dfrc_pkg::t_out_item r_out_item;
    dfrc_pkg::t_out_item result;
    logic                core_ready;
    logic                step;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                dfrc_pkg::CFG_MAX_FRAMES: n_cfg.max_frames = i_cfg_wdata[6:0];
                dfrc_pkg::CFG_FRAME_SIZE: n_cfg.frame_size = i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frames <= dfrc_pkg::MAX_FRAMES_RST;
            r_cfg.frame_size <= dfrc_pkg::FRAME_SIZE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // event moves to the result register when that register is free and the core is ready
    assign step       = r_in_valid && core_ready && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in;
        end
    end

    // ring state and event logic
    dfrc_event_core #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_ready  (core_ready),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out_item;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the frame-slot ring controller against a cycle-free model of the ring
// fill, host slot and DMA flags: directed events first, then random event
// streams under several register settings and idle profiles.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BEATS = 180;

    // block ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [dfrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [dfrc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    dfrc_pkg::t_in_item              i_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    dfrc_pkg::t_out_item             o_out;

    // stimulus and scoreboard storage
    dfrc_pkg::t_in_item  pending_events[$];
    dfrc_pkg::t_out_item expected_results[$];
    int        mismatch_cnt = 0;
    bit        in_taken = 1'b0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;

    // model copy of the ring state and registers
    logic [6:0]  cfg_max_frames = dfrc_pkg::MAX_FRAMES_RST;
    logic [16:0] cfg_frame_size = dfrc_pkg::FRAME_SIZE_RST;
    int          ring_fill = 0;
    int          ring_slot = 0;
    bit          dma_run = 1'b0;
    bit          dma_pause = 1'b0;
    bit          play_mode = 1'b0;

    dma_frame_ring_controller_unit #(
        .MAX_SLOTS (dfrc_pkg::MAX_SLOTS_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // slots in use, clamped to 1..MAX_SLOTS_DEF
    function automatic int ring_emax();
        int m;
        m = int'(cfg_max_frames);
        if (m < 1) m = 1;
        if (m > dfrc_pkg::MAX_SLOTS_DEF) m = dfrc_pkg::MAX_SLOTS_DEF;
        return m;
    endfunction

    // apply one event to the ring model and return the result it yields
    function automatic dfrc_pkg::t_out_item predict_ring_event(dfrc_pkg::t_in_item ev);
        dfrc_pkg::t_out_item r;
        int          emax;
        int          cnt;
        int          base;
        logic [16:0] fs_m1;
        r = '0;
        emax = ring_emax();
        cnt = int'(ev.frames);
        base = (ring_slot >= emax) ? 0 : ring_slot;
        fs_m1 = cfg_frame_size - 17'd1;
        case (ev.mode)
            dfrc_pkg::MODE_REC_SETUP: begin
                ring_fill = 0;
                ring_slot = 0;
                dma_run = 1'b1;
                dma_pause = 1'b0;
                play_mode = 1'b0;
                r.dsp_command = dfrc_pkg::CMD_START_IN;
                r.block_length_minus_one = fs_m1[15:0];
            end
            dfrc_pkg::MODE_PLAY_SETUP: begin
                ring_fill = 0;
                ring_slot = 0;
                dma_run = 1'b0;
                dma_pause = 1'b0;
                play_mode = 1'b1;
            end
            dfrc_pkg::MODE_HOST_WRITE: begin
                if (ring_fill + cnt > emax) begin
                    r.status = dfrc_pkg::STATUS_WR_FULL;
                end else begin
                    r.first_slot = base[5:0];
                    ring_slot = (base + cnt) % emax;
                    ring_fill = ring_fill + cnt;
                    if (!dma_run) begin
                        r.dsp_command = dfrc_pkg::CMD_START_OUT;
                        r.block_length_minus_one = fs_m1[15:0];
                        dma_run = 1'b1;
                    end else if (dma_pause) begin
                        r.dsp_command = dfrc_pkg::CMD_RESTART;
                        dma_pause = 1'b0;
                    end
                end
            end
            dfrc_pkg::MODE_HOST_READ: begin
                if (ring_fill < cnt) begin
                    r.status = dfrc_pkg::STATUS_RD_WAIT;
                end else begin
                    r.first_slot = base[5:0];
                    ring_slot = (base + cnt) % emax;
                    ring_fill = ring_fill - cnt;
                end
            end
            dfrc_pkg::MODE_DMA_DONE: begin
                // playback drains toward underrun, record fills up to the max
                if (play_mode) begin
                    if (ring_fill > 0) begin
                        ring_fill = ring_fill - 1;
                        if (ring_fill == 0) begin
                            r.dsp_command = dfrc_pkg::CMD_PAUSE;
                            dma_pause = 1'b1;
                        end
                    end
                end else if (ring_fill < emax) begin
                    ring_fill = ring_fill + 1;
                end
            end
            default: begin
            end
        endcase
        r.fill_count = ring_fill[6:0];
        r.dma_is_paused = dma_pause;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_cnt++;
    endtask

    // input driver: offers the next pending event beat
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= pending_events.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready, forced low during a hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold-off cycle counter
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: predict accepted events, check accepted result beats
    always @(posedge i_clk) begin : monitor
        dfrc_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(o_out.fill_count), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.status !== want.status)
                        report_mismatch("status", int'(o_out.status), int'(want.status));
                    if (o_out.dsp_command !== want.dsp_command)
                        report_mismatch("dsp_command", int'(o_out.dsp_command),
                            int'(want.dsp_command));
                    if (o_out.block_length_minus_one !== want.block_length_minus_one)
                        report_mismatch("block_length_minus_one",
                            int'(o_out.block_length_minus_one),
                            int'(want.block_length_minus_one));
                    if (o_out.first_slot !== want.first_slot)
                        report_mismatch("first_slot", int'(o_out.first_slot),
                            int'(want.first_slot));
                    if (o_out.fill_count !== want.fill_count)
                        report_mismatch("fill_count", int'(o_out.fill_count),
                            int'(want.fill_count));
                    if (o_out.dma_is_paused !== want.dma_is_paused)
                        report_mismatch("dma_is_paused", int'(o_out.dma_is_paused),
                            int'(want.dma_is_paused));
                end
            end
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_ring_event(i_in));
        end
    end

    task automatic push_event(logic [2:0] m, int n);
        dfrc_pkg::t_in_item ev;
        ev.mode = m;
        ev.frames = n[6:0];
        pending_events.push_back(ev);
    endtask

    // random event, frame counts mostly small or up to the ring size
    task automatic push_random_event();
        int   sel;
        int   fr;
        int   pick;
        logic [2:0] m;
        sel = $urandom_range(99);
        pick = $urandom_range(99);
        if (sel < 4) m = dfrc_pkg::MODE_REC_SETUP;
        else if (sel < 8) m = dfrc_pkg::MODE_PLAY_SETUP;
        else if (sel < 38) m = dfrc_pkg::MODE_HOST_WRITE;
        else if (sel < 66) m = dfrc_pkg::MODE_HOST_READ;
        else if (sel < 96) m = dfrc_pkg::MODE_DMA_DONE;
        else m = 3'($urandom_range(5, 7));
        if (pick < 50) fr = $urandom_range(0, 3);
        else if (pick < 85) fr = $urandom_range(0, ring_emax());
        else fr = $urandom_range(0, 127);
        push_event(m, fr);
    endtask

    // wait until no beat is pending, offered or outstanding
    task automatic wait_ring_idle();
        while (pending_events.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(dfrc_pkg::t_cfg_idx idx, logic [16:0] val);
        wait_ring_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx == dfrc_pkg::CFG_MAX_FRAMES) cfg_max_frames = val[6:0];
        else cfg_frame_size = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // run limit
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [6:0]  max_sel[NUM_PHASES];
        logic [16:0] fs_sel[NUM_PHASES];
        max_sel = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'($urandom_range(1, 64)), 7'd33,
                    7'($urandom_range(1, 64))};
        fs_sel = '{17'd256, 17'd65536, 17'd0, 17'd131071, 17'd1,
                   17'($urandom_range(0, 131071)), 17'd2, 17'($urandom_range(0, 131071))};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: record saturation, overflow, read wait, underrun pause, restart
        push_event(dfrc_pkg::MODE_REC_SETUP, 0);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 63);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 1);
        push_event(dfrc_pkg::MODE_HOST_READ, 127);
        push_event(dfrc_pkg::MODE_HOST_READ, 64);
        push_event(dfrc_pkg::MODE_PLAY_SETUP, 0);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 2);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 1);
        push_event(dfrc_pkg::MODE_HOST_READ, 0);
        push_event(3'd5, 127);
        push_event(3'd6, 85);
        push_event(3'd7, 42);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 127);
        push_event(dfrc_pkg::MODE_HOST_READ, 1);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 50);
        push_event(dfrc_pkg::MODE_HOST_READ, 50);

        // host slot left beyond a shrunken ring restarts at slot zero
        write_cfg(dfrc_pkg::CFG_MAX_FRAMES, 17'd8);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 3);

        // zero frame size wraps the block length, zero max clamps to one slot
        write_cfg(dfrc_pkg::CFG_FRAME_SIZE, 17'd0);
        write_cfg(dfrc_pkg::CFG_MAX_FRAMES, 17'd0);
        push_event(dfrc_pkg::MODE_REC_SETUP, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 1);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 2);
        push_event(dfrc_pkg::MODE_DMA_DONE, 0);
        write_cfg(dfrc_pkg::CFG_FRAME_SIZE, 17'd65536);
        push_event(dfrc_pkg::MODE_PLAY_SETUP, 0);
        push_event(dfrc_pkg::MODE_HOST_WRITE, 0);

        // random phases over register settings and idle profiles
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(dfrc_pkg::CFG_MAX_FRAMES, {10'd0, max_sel[p]});
            write_cfg(dfrc_pkg::CFG_FRAME_SIZE, fs_sel[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 0) hold_req = 1'b1;
            push_event($urandom_range(1) ? dfrc_pkg::MODE_REC_SETUP
                                         : dfrc_pkg::MODE_PLAY_SETUP, 0);
            for (int k = 0; k < PHASE_BEATS / 2; k++) push_random_event();
            // sender pauses until every result is back
            wait_ring_idle();
            for (int k = 0; k < PHASE_BEATS / 2; k++) push_random_event();
        end

        wait_ring_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dfrc_pkg.sv
rtl/dfrc_event_core.sv
rtl/dma_frame_ring_controller_unit.sv
dv/testbench.sv
